// ===== hw/rtl/amcp_pkg.sv =====
// Package for the ASCII motion command parser.
// Holds character codes, direction and status codes, and shared word types.
// No dependencies.
package amcp_pkg;

	localparam int BYTE_W  = 8;
	localparam int DIR_W   = 3;
	localparam int SPEED_W = 8;

	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
	localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd100;

	localparam logic [DIR_W-1:0] DIR_FWD   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_BACK  = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_STOP  = 3'd4;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// one received word
	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              line_error;
	} amcp_item_t;

	// one parsed command word
	typedef struct packed {
		logic [DIR_W-1:0]   direction;
		logic [SPEED_W-1:0] speed;
		logic               status;
	} amcp_result_t;

endpackage

// ===== hw/rtl/amcp_if.sv =====
// Valid/ready channel interfaces for the motion command parser.
// Depends on amcp_pkg for field widths.
interface amcp_rx_if;
	logic                        valid;
	logic                        ready;
	logic [amcp_pkg::BYTE_W-1:0] rx_byte;
	logic                        line_error;

	modport source (output valid, output rx_byte, output line_error, input ready);
	modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

interface amcp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [amcp_pkg::DIR_W-1:0]   direction;
	logic [amcp_pkg::SPEED_W-1:0] speed;
	logic                         status;

	modport source (output valid, output direction, output speed, output status, input ready);
	modport sink   (input valid, input direction, input speed, input status, output ready);
endinterface

interface amcp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [amcp_pkg::SPEED_W-1:0] max_speed;

	modport source (output valid, output max_speed, input ready);
	modport sink   (input valid, input max_speed, output ready);
endinterface

// ===== hw/rtl/amcp_parse.sv =====
// Line assembly and on-the-fly command parse state for one received word.
// Depends on amcp_pkg.
module amcp_parse #(
	parameter int LINE_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  amcp_pkg::amcp_item_t          item,
	input  logic [amcp_pkg::SPEED_W-1:0]  max_speed,
	output logic                          res_valid,
	output amcp_pkg::amcp_result_t        res
);
	import amcp_pkg::*;

	localparam int CW = $clog2(LINE_BYTES);
	localparam logic [CW-1:0] LAST_POS = CW'(LINE_BYTES - 1);

	logic [CW-1:0]      line_count_q, line_count_d;
	logic               discarding_q, discarding_d;
	logic [DIR_W-1:0]   dir_code_q, dir_code_d;
	logic [SPEED_W-1:0] speed_accum_q, speed_accum_d;
	logic               digit_seen_q, digit_seen_d;
	logic               line_bad_q, line_bad_d;
	logic               text_ended_q, text_ended_d;

	logic [BYTE_W-1:0] b;
	logic [11:0]       next_speed;
	logic              cmd_ok;

	assign b = item.rx_byte;
	// accum*10 + digit
	assign next_speed = {1'b0, speed_accum_q, 3'b000} + {3'b000, speed_accum_q, 1'b0}
		+ {8'd0, b[3:0]};

	always_comb begin
		line_count_d  = line_count_q;
		discarding_d  = discarding_q;
		dir_code_d    = dir_code_q;
		speed_accum_d = speed_accum_q;
		digit_seen_d  = digit_seen_q;
		line_bad_d    = line_bad_q;
		text_ended_d  = text_ended_q;
		res_valid     = 1'b0;
		cmd_ok        = !line_bad_q && digit_seen_q &&
			!(dir_code_q == DIR_STOP && speed_accum_q != '0);
		res.direction = cmd_ok ? dir_code_q : '0;
		res.speed     = cmd_ok ? speed_accum_q : '0;
		res.status    = cmd_ok ? STATUS_OK : STATUS_REJECT;

		if (item.line_error || b == CH_LF) begin
			res_valid     = !item.line_error && line_count_q != '0 && !discarding_q;
			line_count_d  = '0;
			discarding_d  = 1'b0;
			dir_code_d    = '0;
			speed_accum_d = '0;
			digit_seen_d  = 1'b0;
			line_bad_d    = 1'b0;
			text_ended_d  = 1'b0;
		end else if (b != CH_CR && !discarding_q) begin
			if (line_count_q < LAST_POS) begin
				line_count_d = line_count_q + 1'b1;
				if (!line_bad_q && !text_ended_q) begin
					if (line_count_q == '0) begin
						case (b)
							CH_F:    dir_code_d = DIR_FWD;
							CH_B:    dir_code_d = DIR_BACK;
							CH_L:    dir_code_d = DIR_LEFT;
							CH_R:    dir_code_d = DIR_RIGHT;
							CH_S:    dir_code_d = DIR_STOP;
							default: line_bad_d = 1'b1;
						endcase
					end else if (line_count_q == CW'(1)) begin
						if (b != CH_COMMA) line_bad_d = 1'b1;
					end else if (b == CH_NUL) begin
						text_ended_d = 1'b1;
					end else if (b < CH_0 || b > CH_9) begin
						line_bad_d = 1'b1;
					end else if (next_speed > {4'd0, max_speed}) begin
						line_bad_d = 1'b1;
					end else begin
						speed_accum_d = next_speed[SPEED_W-1:0];
						digit_seen_d  = 1'b1;
					end
				end
			end else begin
				// overflow: drop the line until newline
				line_count_d  = '0;
				discarding_d  = 1'b1;
				dir_code_d    = '0;
				speed_accum_d = '0;
				digit_seen_d  = 1'b0;
				line_bad_d    = 1'b0;
				text_ended_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q  <= '0;
			discarding_q  <= 1'b0;
			dir_code_q    <= '0;
			speed_accum_q <= '0;
			digit_seen_q  <= 1'b0;
			line_bad_q    <= 1'b0;
			text_ended_q  <= 1'b0;
		end else if (step_en) begin
			line_count_q  <= line_count_d;
			discarding_q  <= discarding_d;
			dir_code_q    <= dir_code_d;
			speed_accum_q <= speed_accum_d;
			digit_seen_q  <= digit_seen_d;
			line_bad_q    <= line_bad_d;
			text_ended_q  <= text_ended_d;
		end
	end

endmodule

// ===== hw/rtl/ascii_motion_command_parser_core.sv =====
// ASCII motion command parser, top level.
// An accepted word enters the input register, its command word then the result register.
// Throughput: one received word per cycle while cmd is not stalled; the input and result
//   registers are parted, so a waiting command stalls intake only once the input slot fills.
// Reset: arst_n clears line and parse state, empties both registers, max_speed = 100.
// Depends on amcp_pkg, amcp_if.sv and amcp_parse.
module ascii_motion_command_parser_core #(
	parameter int LINE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	amcp_rx_if.sink     rx,
	amcp_cmd_if.source  cmd,
	amcp_cfg_if.sink    cfg
);
	import amcp_pkg::*;

	// input stage
	logic         valid_s1;
	amcp_item_t   item_s1;

	// result stage
	logic         out_valid_q;
	amcp_result_t result_q;

	logic [SPEED_W-1:0] max_speed_q;

	logic         advance;   // result register can take a new value
	logic         step_en;   // stage-1 word is processed this cycle
	logic         res_valid;
	amcp_result_t res;

	assign advance  = !out_valid_q || cmd.ready;
	assign step_en  = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// register the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1.rx_byte    <= rx.rx_byte;
			item_s1.line_error <= rx.line_error;
		end
	end

	// speed limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
		end else if (cfg.valid) begin
			max_speed_q <= cfg.max_speed;
		end
	end

	// line state and parse step
	amcp_parse #(
		.LINE_BYTES (LINE_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.item      (item_s1),
		.max_speed (max_speed_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register; only a newline closing a live line produces a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid) begin
			result_q <= res;
		end
	end

	assign cmd.valid     = out_valid_q;
	assign cmd.direction = result_q.direction;
	assign cmd.speed     = result_q.speed;
	assign cmd.status    = result_q.status;

endmodule
